// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is switched off while reset is high
`define CHK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// clocked assertion that also holds across reset
`define CHK_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ===== rtl/tfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfcc_pkg
// Types and constants for the tracking frame CRC checker: frame word
// positions, CRC-16 polynomial and start value, marker nibbles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfcc_pkg;

  typedef logic [3:0]  word_idx_t;
  typedef logic [15:0] word_t;
  typedef logic [3:0]  nibble_t;

  // reflected CRC-16, LSB first, no final xor
  localparam word_t CRC_POLY = 16'h8408;
  localparam word_t CRC_INIT = 16'hFFFF;

  // word positions within a frame
  localparam word_idx_t IDX_BC        = 4'd0;
  localparam word_idx_t IDX_EC        = 4'd1;
  localparam word_idx_t IDX_CHIP      = 4'd2;
  localparam word_idx_t IDX_HIGH_LAST = 4'd6;
  localparam word_idx_t IDX_CRC       = 4'd11;

  // header marker nibbles
  localparam nibble_t MARK_BC   = 4'hA;
  localparam nibble_t MARK_EC   = 4'hC;
  localparam nibble_t MARK_CHIP = 4'hE;

endpackage

`default_nettype wire

// ===== rtl/tfcc_crc_step.sv =====
// ----------------------------------------------------------------------------
// tfcc_crc_step
// One full 16-bit word step of the reflected CRC-16, unrolled to a
// single xor network.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfcc_crc_step (
  input  wire tfcc_pkg::word_t crc_in,
  input  wire tfcc_pkg::word_t data,
  output tfcc_pkg::word_t      crc_out
);

  tfcc_pkg::word_t crc_work;

  // sixteen bit steps, data LSB first
  always_comb begin
    crc_work = crc_in;
    for (int k = 0; k < 16; k++) begin
      if (crc_work[0] ^ data[k]) begin
        crc_work = (crc_work >> 1) ^ tfcc_pkg::CRC_POLY;
      end else begin
        crc_work = crc_work >> 1;
      end
    end
    crc_out = crc_work;
  end

endmodule

`default_nettype wire

// ===== rtl/tracking_frame_crc_checker.sv =====
// The result is registered on acceptance of a frame's CRC word.
// Throughput: one frame word per cycle unless stalled; the CRC step is one unrolled
//   16-bit xor network between the port and the running CRC register.
// Input stalls only when a CRC word arrives while the last result waits.
// Reset (rst, synchronous): word index to frame start, CRC to 0xFFFF,
//   no result pending.
// ----------------------------------------------------------------------------
// tracking_frame_crc_checker
// Collects a twelve-word tracking frame, unpacks header fields and channel
// bits, checks marker nibbles and the CRC-16 of the first eleven words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tracking_frame_crc_checker (
  input  wire         clk,
  input  wire         rst,
  // request input
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [15:0] data_word,
  input  wire         frame_start,
  // result output
  output logic        out_valid,
  input  wire         out_stall,
  output logic [11:0] bunch_crossing,
  output logic [7:0]  event_count,
  output logic [3:0]  event_flags,
  output logic [11:0] chip_ident,
  output logic [63:0] channels_high,
  output logic [63:0] channels_low,
  output logic        markers_ok,
  output logic [15:0] crc_received,
  output logic [15:0] crc_computed,
  output logic        crc_match
);

  tfcc_pkg::word_idx_t word_index;
  tfcc_pkg::word_t     crc_accum;
  tfcc_pkg::word_t     bc_store;
  tfcc_pkg::word_t     ec_store;
  tfcc_pkg::word_t     chip_store;
  logic [63:0]         high_bits_store;
  logic [63:0]         low_bits_store;

  logic                frame_restart;
  tfcc_pkg::word_idx_t idx_cur;
  tfcc_pkg::word_t     crc_cur;
  tfcc_pkg::word_t     crc_next;
  logic                last_word;
  logic                accept;
  logic                markers_good;

  // frame position of the offered word
  assign frame_restart = frame_start || (word_index > tfcc_pkg::IDX_CRC);
  assign idx_cur       = frame_restart ? tfcc_pkg::IDX_BC : word_index;
  assign crc_cur       = frame_restart ? tfcc_pkg::CRC_INIT : crc_accum;
  assign last_word     = (idx_cur == tfcc_pkg::IDX_CRC);

  // hold off only a CRC word that would overwrite a waiting result
  assign in_stall = out_valid && out_stall && last_word;
  assign accept   = in_valid && !in_stall;

  // running CRC
  tfcc_crc_step u_crc_step (
    .crc_in  (crc_cur),
    .data    (data_word),
    .crc_out (crc_next)
  );

  // frame position and CRC registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= tfcc_pkg::IDX_BC;
      crc_accum  <= tfcc_pkg::CRC_INIT;
    end else if (accept) begin
      if (last_word) begin
        word_index <= tfcc_pkg::IDX_BC;
        crc_accum  <= tfcc_pkg::CRC_INIT;
      end else begin
        word_index <= idx_cur + 4'd1;
        crc_accum  <= crc_next;
      end
    end
  end

  // header and channel word stores
  always_ff @(posedge clk) begin
    if (accept && !last_word) begin
      priority if (idx_cur == tfcc_pkg::IDX_BC) begin
        bc_store <= data_word;
      end else if (idx_cur == tfcc_pkg::IDX_EC) begin
        ec_store <= data_word;
      end else if (idx_cur == tfcc_pkg::IDX_CHIP) begin
        chip_store <= data_word;
      end else if (idx_cur <= tfcc_pkg::IDX_HIGH_LAST) begin
        high_bits_store <= {high_bits_store[47:0], data_word};
      end else begin
        low_bits_store <= {low_bits_store[47:0], data_word};
      end
    end
  end

  // marker nibble check
  assign markers_good = (bc_store[15:12]   == tfcc_pkg::MARK_BC) &&
                        (ec_store[15:12]   == tfcc_pkg::MARK_EC) &&
                        (chip_store[15:12] == tfcc_pkg::MARK_CHIP);

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_word) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept && last_word) begin
      bunch_crossing <= bc_store[11:0];
      event_count    <= ec_store[11:4];
      event_flags    <= ec_store[3:0];
      chip_ident     <= chip_store[11:0];
      channels_high  <= high_bits_store;
      channels_low   <= low_bits_store;
      markers_ok     <= markers_good;
      crc_received   <= data_word;
      crc_computed   <= crc_accum;
      crc_match      <= (data_word == crc_accum);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tfcc_checker.sv =====
// ----------------------------------------------------------------------------
// tfcc_checker
// Port-level checks on the tracking frame CRC checker, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tfcc_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] crc_received,
  input wire [15:0] crc_computed,
  input wire        crc_match
);

  // no result pending straight after reset
  `CHK_ASSERT_NORST(a_reset_clears_out, clk, rst |=> !out_valid)

  // a stalled result stays put
  `CHK_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(crc_received))

  // match flag agrees with the two CRC values
  `CHK_ASSERT(a_match_flag, clk, rst, out_valid |-> (crc_match == (crc_received == crc_computed)))

  // input is held off only behind a waiting, stalled result
  `CHK_ASSERT(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall)

endmodule

bind tracking_frame_crc_checker tfcc_checker u_tfcc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .crc_received (crc_received),
  .crc_computed (crc_computed),
  .crc_match    (crc_match)
);

`default_nettype wire

// ===== tb/frame_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches both channels of the tracking frame CRC checker. Every accepted
// frame word is run through a local copy of the frame unpacker and CRC-16;
// each CRC word queues the frame result it should produce, and every
// accepted result is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module frame_result_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [15:0] data_word,
  input  wire         frame_start,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [11:0] bunch_crossing,
  input  wire  [7:0]  event_count,
  input  wire  [3:0]  event_flags,
  input  wire  [11:0] chip_ident,
  input  wire  [63:0] channels_high,
  input  wire  [63:0] channels_low,
  input  wire         markers_ok,
  input  wire  [15:0] crc_received,
  input  wire  [15:0] crc_computed,
  input  wire         crc_match,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [11:0] bunch_crossing;
    logic [7:0]  event_count;
    logic [3:0]  event_flags;
    logic [11:0] chip_ident;
    logic [63:0] channels_high;
    logic [63:0] channels_low;
    logic        markers_ok;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
    logic        crc_match;
  } frame_result_t;

  frame_result_t frame_results_q[$];

  // local frame state
  tfcc_pkg::word_idx_t frame_pos;
  tfcc_pkg::word_t     crc_run;
  tfcc_pkg::word_t     bc_word;
  tfcc_pkg::word_t     ec_word;
  tfcc_pkg::word_t     chip_word;
  logic [63:0]         high_bits;
  logic [63:0]         low_bits;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // one word through the reflected crc, lsb first
  function automatic tfcc_pkg::word_t crc16_word(input tfcc_pkg::word_t crc_in,
                                                 input tfcc_pkg::word_t w);
    tfcc_pkg::word_t c;
    c = crc_in;
    for (int k = 0; k < 16; k++) begin
      if (c[0] ^ w[k]) c = (c >> 1) ^ tfcc_pkg::CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      if (errors < 10)
        $display("frame checker: %s expected %h got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t       want;
    tfcc_pkg::word_idx_t idx;
    if (rst) begin
      frame_pos = tfcc_pkg::IDX_BC;
      crc_run   = tfcc_pkg::CRC_INIT;
      bc_word   = '0;
      ec_word   = '0;
      chip_word = '0;
      high_bits = '0;
      low_bits  = '0;
      frame_results_q.delete();
    end else begin
      // result side first: a result never stems from a word of this edge
      if (out_valid && !out_stall) begin
        if (frame_results_q.size() == 0) begin
          if (errors < 10) $display("frame checker: result with none expected");
          errors++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("bunch_crossing", want.bunch_crossing, bunch_crossing);
          check_field("event_count", want.event_count, event_count);
          check_field("event_flags", want.event_flags, event_flags);
          check_field("chip_ident", want.chip_ident, chip_ident);
          check_field("channels_high", want.channels_high, channels_high);
          check_field("channels_low", want.channels_low, channels_low);
          check_field("markers_ok", want.markers_ok, markers_ok);
          check_field("crc_received", want.crc_received, crc_received);
          check_field("crc_computed", want.crc_computed, crc_computed);
          check_field("crc_match", want.crc_match, crc_match);
        end
      end

      // request side: step the local frame state
      if (in_valid && !in_stall) begin
        if (frame_start) begin
          frame_pos = tfcc_pkg::IDX_BC;
          crc_run   = tfcc_pkg::CRC_INIT;
        end
        idx = frame_pos;
        // positions past the crc word behave as frame start
        if (idx > tfcc_pkg::IDX_CRC) begin
          idx     = tfcc_pkg::IDX_BC;
          crc_run = tfcc_pkg::CRC_INIT;
        end
        if (idx == tfcc_pkg::IDX_CRC) begin
          want.bunch_crossing = bc_word[11:0];
          want.event_count    = ec_word[11:4];
          want.event_flags    = ec_word[3:0];
          want.chip_ident     = chip_word[11:0];
          want.channels_high  = high_bits;
          want.channels_low   = low_bits;
          want.markers_ok     = (bc_word[15:12] == tfcc_pkg::MARK_BC) &&
                                (ec_word[15:12] == tfcc_pkg::MARK_EC) &&
                                (chip_word[15:12] == tfcc_pkg::MARK_CHIP);
          want.crc_received   = data_word;
          want.crc_computed   = crc_run;
          want.crc_match      = (data_word == crc_run);
          frame_results_q.push_back(want);
          frame_pos = tfcc_pkg::IDX_BC;
          crc_run   = tfcc_pkg::CRC_INIT;
        end else begin
          crc_run = crc16_word(crc_run, data_word);
          if (idx == tfcc_pkg::IDX_BC) bc_word = data_word;
          else if (idx == tfcc_pkg::IDX_EC) ec_word = data_word;
          else if (idx == tfcc_pkg::IDX_CHIP) chip_word = data_word;
          else if (idx <= tfcc_pkg::IDX_HIGH_LAST)
            high_bits = {high_bits[47:0], data_word};
          else low_bits = {low_bits[47:0], data_word};
          frame_pos = idx + 4'd1;
        end
      end
    end
    pending <= frame_results_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives twelve-word tracking frames into the CRC checker: a few directed
// frames, then mostly well-formed random frames with good or bad CRC and
// markers, mixed with cut-short frames and loose words. Both channels idle
// at random; the frame checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic [15:0] data_word   = 16'h0000;
  logic        frame_start = 1'b0;
  logic        out_stall   = 1'b0;

  wire         in_stall;
  wire         out_valid;
  wire  [11:0] bunch_crossing;
  wire  [7:0]  event_count;
  wire  [3:0]  event_flags;
  wire  [11:0] chip_ident;
  wire  [63:0] channels_high;
  wire  [63:0] channels_low;
  wire         markers_ok;
  wire  [15:0] crc_received;
  wire  [15:0] crc_computed;
  wire         crc_match;

  int errors;
  int pending;
  int words_sent = 0;

  always #6 clk = ~clk;

  tracking_frame_crc_checker uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_word      (data_word),
    .frame_start    (frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bunch_crossing (bunch_crossing),
    .event_count    (event_count),
    .event_flags    (event_flags),
    .chip_ident     (chip_ident),
    .channels_high  (channels_high),
    .channels_low   (channels_low),
    .markers_ok     (markers_ok),
    .crc_received   (crc_received),
    .crc_computed   (crc_computed),
    .crc_match      (crc_match)
  );

  frame_result_checker chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_word      (data_word),
    .frame_start    (frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bunch_crossing (bunch_crossing),
    .event_count    (event_count),
    .event_flags    (event_flags),
    .chip_ident     (chip_ident),
    .channels_high  (channels_high),
    .channels_low   (channels_low),
    .markers_ok     (markers_ok),
    .crc_received   (crc_received),
    .crc_computed   (crc_computed),
    .crc_match      (crc_match),
    .errors         (errors),
    .pending        (pending)
  );

  // one request, then a random gap unless in a no-idle stretch
  task automatic send_word(input tfcc_pkg::word_t w, input logic s);
    int  gap;
    int  r;
    bit  no_idle;
    in_valid    <= 1'b1;
    data_word   <= w;
    frame_start <= s;
    do @(posedge clk); while (in_stall);
    words_sent++;
    no_idle = (words_sent >= 150 && words_sent < 230) ||
              (words_sent >= 350 && words_sent < 400);
    gap = 0;
    if (!no_idle) begin
      r = $urandom_range(0, 99);
      if (r >= 96) gap = $urandom_range(10, 30);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // builds a frame with its crc word and sends its first len words
  task automatic send_frame(input tfcc_pkg::word_t bc, input tfcc_pkg::word_t ec,
                            input tfcc_pkg::word_t chip,
                            input logic [127:0] chans, input bit good_crc,
                            input bit flag_first, input int len);
    tfcc_pkg::word_t words [12];
    tfcc_pkg::word_t crc;
    words[0] = bc;
    words[1] = ec;
    words[2] = chip;
    for (int i = 0; i < 8; i++) words[3+i] = chans[127-16*i -: 16];
    crc = tfcc_pkg::CRC_INIT;
    for (int i = 0; i < 11; i++)
      for (int k = 0; k < 16; k++)
        crc = (crc[0] ^ words[i][k]) ? ((crc >> 1) ^ tfcc_pkg::CRC_POLY) : (crc >> 1);
    words[11] = good_crc ? crc : (crc ^ tfcc_pkg::word_t'($urandom_range(1, 65535)));
    for (int i = 0; i < len; i++) send_word(words[i], (i == 0) && flag_first);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off while requests keep coming
  initial begin
    int run;
    int hold;
    bit held;
    held = 0;
    @(posedge clk);
    forever begin
      if (!held && words_sent >= 160) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        held = 1;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      hold = $urandom_range(0, 19);
      if (hold >= 18) hold = $urandom_range(15, 40);
      else if (hold >= 8) hold = $urandom_range(1, 3);
      else hold = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // request side and verdict
  initial begin
    int              sel;
    bit              aligned;
    bit              paused;
    bit              good_marks;
    bit              flag;
    tfcc_pkg::word_t bc;
    tfcc_pkg::word_t ec;
    tfcc_pkg::word_t chip;
    logic [127:0]    chans;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // extremes: all ones with good markers and crc
    send_frame({tfcc_pkg::MARK_BC, 12'hFFF}, {tfcc_pkg::MARK_EC, 12'hFFF},
               {tfcc_pkg::MARK_CHIP, 12'hFFF}, {128{1'b1}}, 1'b1, 1'b1, 12);
    // all zeros, bad markers and crc, no start flag right after a frame end
    send_frame(16'h0000, 16'h0000, 16'h0000, '0, 1'b0, 1'b0, 12);
    // abandoned frame, dropped by the next start flag
    send_frame({tfcc_pkg::MARK_BC, 12'h5A5}, {tfcc_pkg::MARK_EC, 12'h3C3},
               {tfcc_pkg::MARK_CHIP, 12'h0F0},
               {$urandom, $urandom, $urandom, $urandom}, 1'b1, 1'b1, 3);
    aligned = 0;
    paused  = 0;

    while (words_sent < 450) begin
      sel        = $urandom_range(0, 99);
      good_marks = ($urandom_range(0, 4) != 0);
      bc    = {good_marks ? tfcc_pkg::MARK_BC : tfcc_pkg::nibble_t'($urandom_range(0, 15)),
               12'($urandom_range(0, 4095))};
      ec    = {good_marks ? tfcc_pkg::MARK_EC : tfcc_pkg::nibble_t'($urandom_range(0, 15)),
               12'($urandom_range(0, 4095))};
      chip  = {good_marks ? tfcc_pkg::MARK_CHIP : tfcc_pkg::nibble_t'($urandom_range(0, 15)),
               12'($urandom_range(0, 4095))};
      chans = {$urandom, $urandom, $urandom, $urandom};
      if (sel < 80) begin
        flag = !aligned || ($urandom_range(0, 3) != 0);
        send_frame(bc, ec, chip, chans, $urandom_range(0, 9) < 6, flag, 12);
        aligned = 1;
      end else if (sel < 90) begin
        send_frame(bc, ec, chip, chans, 1'b1, 1'b1, $urandom_range(1, 11));
        aligned = 0;
      end else begin
        repeat ($urandom_range(1, 5))
          send_word(tfcc_pkg::word_t'($urandom_range(0, 65535)),
                    $urandom_range(0, 3) == 0);
        aligned = 0;
      end
      // one pause until every frame result is out
      if (!paused && words_sent >= 260) begin
        wait_results_drained();
        paused = 1;
      end
    end

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tracking_frame_crc_checker: match");
    end else begin
      $display("tracking_frame_crc_checker: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tracking_frame_crc_checker: mismatch");
    $finish;
  end

endmodule
